// ===== rtl/core/sgm_pkg.sv =====
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared widths, codes and helpers of the sequence gap monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package sgm_pkg;

	// Table size and sequence number width
	localparam int NUM_SOURCES = 256;
	localparam int SEQ_BITS    = 16;
	localparam int SRC_W       = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

	// Fixed field widths
	localparam int ID_W      = 8;
	localparam int LEN_W     = 8;
	localparam int SEQ_IN_W  = 16;
	localparam int VERDICT_W = 3;
	localparam int MISSED_W  = 15;
	localparam int CNT_W     = 32;
	localparam int GAP_CFG_W = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 15;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 176;

	// Shortest frame that carries a sequence number, reset values
	localparam logic [LEN_W-1:0]     MIN_SEQ_LEN   = LEN_W'(2);
	localparam logic [GAP_CFG_W-1:0] GAP_RESET_VAL = GAP_CFG_W'(32);
	localparam logic [LEN_W-1:0]     FLEN_RESET_VAL = LEN_W'(255);

	typedef enum logic [VERDICT_W-1:0] {
		V_FIRST   = 3'd0,
		V_INORDER = 3'd1,
		V_GAP     = 3'd2,
		V_RESET   = 3'd3,
		V_NOSEQ   = 3'd4,
		V_REJECT  = 3'd5
	} verdict_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_FORWARD_GAP = 2'd0,
		REG_MAX_FRAME_LEN   = 2'd1
	} cfg_reg_t;

	// Fold a source id into the table range
	function automatic logic [SRC_W-1:0] src_fold(input logic [ID_W-1:0] id);
		logic [ID_W:0] wide;
		wide = {1'b0, id};
		return SRC_W'(wide % (ID_W+1)'(NUM_SOURCES));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sgm_ram.sv =====
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module sgm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/sequence_gap_monitor.sv =====
// ----------------------------------------------------------------------------
// sequence_gap_monitor
// Per-source sequence number gap detector for audio frame descriptors.
// ----------------------------------------------------------------------------
// One beat in, one beat out. A descriptor beat is accepted every cycle while
// the output is not stalled. The accepting edge launches the read of the
// source's last sequence number from a synchronous table with one write and
// one read port, and loads the descriptor into stage 1. Once the output
// register is free or being drained, stage 1 classifies the frame, updates
// the running counters and writes the table back for a frame with a sequence
// number, and the verdict then sits in the output register. A write to the
// same source by the frame just ahead is forwarded, so back-to-back frames of
// one source sustain one per cycle while the output is not stalled. Seen flags
// live in flip-flops and clear at once on reset; no clearing pass is needed.
// Configuration writes are accepted whenever cfg_valid is high (cfg_ready is
// always high) and must only be issued while no frame is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_gap_monitor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// Descriptor input
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// source_id [7:0], frame_len [15:8], seq_num [31:16]
	input  wire logic [sgm_pkg::IN_TDATA_W-1:0]  s_tdata,
	// Verdict output
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// missed_frames [14:0], accepted_count [46:15], checked_count [78:47],
	// gap_event_count [110:79], gap_frame_count [142:111],
	// reset_event_count [174:143], zero [175]
	output logic [sgm_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// verdict [2:0]
	output logic [sgm_pkg::VERDICT_W-1:0]        m_tuser,
	// Configuration write
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [sgm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [sgm_pkg::CFG_DAT_W-1:0]   cfg_data
);

	import sgm_pkg::*;

	// Configuration registers
	logic [GAP_CFG_W-1:0] max_gap_q;
	logic [LEN_W-1:0]     max_len_q;

	// Stage 1: descriptor waiting for its table read
	logic                 vld_s1;
	logic [SRC_W-1:0]     src_s1;
	logic [LEN_W-1:0]     flen_s1;
	logic [SEQ_BITS-1:0]  seq_s1;

	// Most recent table write, for forwarding
	logic                 wvld_q;
	logic [SRC_W-1:0]     waddr_q;
	logic [SEQ_BITS-1:0]  wdata_q;

	// Seen flags, one per source
	logic [NUM_SOURCES-1:0] seen_q;

	// Running counters, output register
	logic [CNT_W-1:0]     acc_cnt_q;
	logic [CNT_W-1:0]     chk_cnt_q;
	logic [CNT_W-1:0]     gap_evt_q;
	logic [CNT_W-1:0]     gap_frm_q;
	logic [CNT_W-1:0]     rst_evt_q;
	logic                 out_vld_q;
	verdict_t             verdict_q;
	logic [MISSED_W-1:0]  missed_q;

	// Handshake and table access
	logic                 accept;
	logic                 adv_s1;
	logic [SRC_W-1:0]     in_src;
	logic [SEQ_BITS-1:0]  ram_rd_data;
	logic                 tbl_wr;

	// Classification
	logic                 too_long;
	logic                 has_seq;
	logic                 seen_src;
	logic [SEQ_BITS-1:0]  prev_seq;
	logic [SEQ_BITS-1:0]  delta;
	logic                 is_gap;
	verdict_t             verdict_d;
	logic [MISSED_W-1:0]  missed_d;

	assign cfg_ready = 1'b1;

	// Stage 1 moves on whenever the output register is free or being drained
	assign adv_s1   = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || adv_s1;
	assign accept   = s_tvalid && s_tready;
	assign in_src   = src_fold(s_tdata[ID_W-1:0]);

	// Table of last sequence numbers: read at acceptance, written on advance of a frame with a sequence number
	sgm_ram #(
		.WIDTH (SEQ_BITS),
		.DEPTH (NUM_SOURCES)
	) u_seq_tbl (
		.clk     (clk),
		.wr_en   (tbl_wr),
		.wr_addr (src_s1),
		.wr_data (seq_s1),
		.rd_en   (accept),
		.rd_addr (in_src),
		.rd_data (ram_rd_data)
	);

	// Classify the frame in stage 1
	always_comb begin
		too_long = flen_s1 > max_len_q;
		has_seq  = !too_long && (flen_s1 >= MIN_SEQ_LEN);
		seen_src = seen_q[src_s1];
		// Forward the write that overlapped this frame's table read
		prev_seq = (wvld_q && (waddr_q == src_s1)) ? wdata_q : ram_rd_data;
		delta    = seq_s1 - (prev_seq + SEQ_BITS'(1));
		// Forward jumps only: nonzero, below half the sequence space, within limit
		is_gap   = (delta != '0) && !delta[SEQ_BITS-1]
			&& (CNT_W'(delta) <= CNT_W'(max_gap_q));
		missed_d = '0;
		if (too_long) begin
			verdict_d = V_REJECT;
		end else if (!has_seq) begin
			verdict_d = V_NOSEQ;
		end else if (!seen_src) begin
			verdict_d = V_FIRST;
		end else if (delta == '0) begin
			verdict_d = V_INORDER;
		end else if (is_gap) begin
			verdict_d = V_GAP;
			missed_d  = MISSED_W'(delta);
		end else begin
			verdict_d = V_RESET;
		end
	end

	assign tbl_wr = adv_s1 && has_seq;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= GAP_RESET_VAL;
			max_len_q <= FLEN_RESET_VAL;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MAX_FORWARD_GAP: max_gap_q <= GAP_CFG_W'(cfg_data);
				REG_MAX_FRAME_LEN:   max_len_q <= LEN_W'(cfg_data);
				default:             ;
			endcase
		end
	end

	// Stage 1 register: hold while stalled, load on acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1  <= in_src;
			flen_s1 <= s_tdata[ID_W +: LEN_W];
			seq_s1  <= SEQ_BITS'(s_tdata[ID_W+LEN_W +: SEQ_IN_W]);
		end
	end

	// Forwarding register and seen flags follow each table write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvld_q <= 1'b0;
			seen_q <= '0;
		end else if (tbl_wr) begin
			wvld_q         <= 1'b1;
			seen_q[src_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			waddr_q <= src_s1;
			wdata_q <= seq_s1;
		end
	end

	// Counters advance with the frame; they double as the output payload,
	// since no newer frame can update them while a verdict is pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
			chk_cnt_q <= '0;
			gap_evt_q <= '0;
			gap_frm_q <= '0;
			rst_evt_q <= '0;
		end else if (adv_s1) begin
			if (!too_long) begin
				acc_cnt_q <= acc_cnt_q + CNT_W'(1);
			end
			if (has_seq) begin
				chk_cnt_q <= chk_cnt_q + CNT_W'(1);
			end
			if (verdict_d == V_GAP) begin
				gap_evt_q <= gap_evt_q + CNT_W'(1);
				gap_frm_q <= gap_frm_q + CNT_W'(missed_d);
			end
			if (verdict_d == V_RESET) begin
				rst_evt_q <= rst_evt_q + CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv_s1) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			verdict_q <= verdict_d;
			missed_q  <= missed_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = verdict_q;
	assign m_tdata  = {1'b0, rst_evt_q, gap_frm_q, gap_evt_q, chk_cnt_q, acc_cnt_q, missed_q};

endmodule

`default_nettype wire
